FILE: rtl/core/mtu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtu_pkg
// Shared constants, types and twist helpers for the untempered twister.
// ----------------------------------------------------------------------------
package mtu_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int WORD_W       = 32;
  // Position counter must also hold STATE_WORDS (store exhausted).
  localparam int ADDR_W       = $clog2(STATE_WORDS + 1);

  localparam logic [ADDR_W-1:0] WORDS_A   = ADDR_W'(STATE_WORDS);
  localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] WRAP_A    = ADDR_W'(STATE_WORDS - SHIFT_OFFSET);
  localparam logic [ADDR_W-1:0] OFFSET_A  = ADDR_W'(SHIFT_OFFSET);

  localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908_B0DF;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_DRAW = 1'b1;

  // Store access request: one write port, two read ports.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              a_en;
    logic [ADDR_W-1:0] a_addr;
    logic              b_en;
    logic [ADDR_W-1:0] b_addr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] k);
    logic [ADDR_W-1:0] r;
    r = (k == LAST_A) ? '0 : k + ADDR_W'(1);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] ahead_index(input logic [ADDR_W-1:0] k);
    logic [ADDR_W-1:0] r;
    r = (k >= WRAP_A) ? k - WRAP_A : k + OFFSET_A;
    return r;
  endfunction

  // New word k from upper bit of word k, low bits of word k+1, and word k+offset.
  function automatic logic [WORD_W-1:0] twist_word(input logic [WORD_W-1:0] upper,
                                                   input logic [WORD_W-1:0] lower,
                                                   input logic [WORD_W-1:0] ahead);
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] r;
    mix = {upper[WORD_W-1], lower[WORD_W-2:0]};
    r   = ahead ^ (mix >> 1);
    if (mix[0]) begin
      r = r ^ TWIST_XOR;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mtu_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtu_store
// State RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mtu_store (
  input  wire logic                          clk,
  input  wire mtu_pkg::mem_req_t             req,
  output logic      [mtu_pkg::WORD_W-1:0]    rd_a,
  output logic      [mtu_pkg::WORD_W-1:0]    rd_b
);

  logic [mtu_pkg::WORD_W-1:0] mem [0:mtu_pkg::STATE_WORDS-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    // read data holds when the port is idle
    if (req.a_en) begin
      rd_a <= mem[req.a_addr];
    end
    if (req.b_en) begin
      rd_b <= mem[req.b_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mersenne_twister_untempered.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mersenne_twister_untempered
// 624-word 32-bit twister generator, seeded word by word, untempered output.
// ----------------------------------------------------------------------------
// After reset the block clears the state RAM to zero (s_tready low), then
// takes words. A load word (s_tuser = 0) writes seed_word at seed_index
// (indexes 624 and up write nothing), rewinds the read position and
// produces no output. A draw word (s_tuser = 1) returns the state word at
// the read position and advances it; the word is read from the registered
// RAM port and then loaded into the output register. When all 624 words
// have been returned, the next draw first regenerates the whole store in
// place: one word per cycle through the dual-read RAM. Until the first
// regeneration the seed words come out as loaded. Outputs are not tempered.
// A pending output word does not block the input side; a draw waits in
// DELIVER only if the output register is full.
// ----------------------------------------------------------------------------
module mersenne_twister_untempered (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [9:0] seed_index, [41:10] seed_word, [47:42] zero
  input  wire logic        s_tuser,   // [0] action: 0 load, 1 draw
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata    // [31:0] random_word
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DELIVER,
    S_PRIME,
    S_TWIST
  } state_t;

  state_t state;

  logic [mtu_pkg::ADDR_W-1:0] pos;    // words returned since last load/twist
  logic [mtu_pkg::ADDR_W-1:0] idx;    // clear sweep / twist issue index
  logic [mtu_pkg::ADDR_W-1:0] s2_k;   // twist word being written
  logic                       s2_valid;
  logic [mtu_pkg::WORD_W-1:0] tw_cur; // old value of word s2_k

  mtu_pkg::mem_req_t          req;
  logic [mtu_pkg::WORD_W-1:0] rd_a;
  logic [mtu_pkg::WORD_W-1:0] rd_b;

  logic                       in_fire;
  logic                       out_free;
  logic [mtu_pkg::ADDR_W-1:0] in_index;
  logic [mtu_pkg::WORD_W-1:0] in_word;
  logic                       twist_last;

  assign s_tready   = (state == S_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign in_index   = s_tdata[9:0];
  assign in_word    = s_tdata[41:10];
  assign twist_last = s2_valid && (s2_k == mtu_pkg::LAST_A);

  mtu_store u_store (
    .clk  (clk),
    .req  (req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  // RAM requests
  always_comb begin
    req = '0;
    case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = idx;
        req.wdata = '0;
      end
      S_IDLE: begin
        if (in_fire) begin
          if (s_tuser == mtu_pkg::ACTION_LOAD) begin
            req.we    = (in_index < mtu_pkg::WORDS_A);
            req.waddr = in_index;
            req.wdata = in_word;
          end else if (pos != mtu_pkg::WORDS_A) begin
            req.a_en   = 1'b1;
            req.a_addr = pos;
          end
        end
      end
      S_PRIME: begin
        // old word 0 seeds the sliding window
        req.a_en   = 1'b1;
        req.a_addr = '0;
      end
      S_TWIST: begin
        // write stage: new word s2_k from window and the word ahead
        req.we    = s2_valid;
        req.waddr = s2_k;
        req.wdata = mtu_pkg::twist_word(tw_cur, rd_a, rd_b);
        if (idx != mtu_pkg::WORDS_A) begin
          // read stage: next word and the word SHIFT_OFFSET ahead
          req.a_en   = 1'b1;
          req.a_addr = mtu_pkg::next_index(idx);
          req.b_en   = 1'b1;
          req.b_addr = mtu_pkg::ahead_index(idx);
        end else if (twist_last) begin
          // regenerated: fetch word 0 for this draw
          req.a_en   = 1'b1;
          req.a_addr = '0;
        end
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      pos      <= '0;
      idx      <= '0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      // DELIVER reloads the output register itself
      if (m_tvalid && m_tready && (state != S_DELIVER)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          idx <= idx + mtu_pkg::ADDR_W'(1);
          if (idx == mtu_pkg::LAST_A) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (s_tuser == mtu_pkg::ACTION_LOAD) begin
              pos <= '0;
            end else if (pos == mtu_pkg::WORDS_A) begin
              state <= S_PRIME;
            end else begin
              pos   <= pos + mtu_pkg::ADDR_W'(1);
              state <= S_DELIVER;
            end
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            m_tdata  <= rd_a;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_PRIME: begin
          idx   <= '0;
          state <= S_TWIST;
        end
        S_TWIST: begin
          tw_cur <= rd_a;
          if (idx != mtu_pkg::WORDS_A) begin
            s2_valid <= 1'b1;
            s2_k     <= idx;
            idx      <= idx + mtu_pkg::ADDR_W'(1);
          end else begin
            s2_valid <= 1'b0;
          end
          if (twist_last) begin
            pos   <= mtu_pkg::ADDR_W'(1);
            state <= S_DELIVER;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
